>>> rtl/core/mrfp_pkg.sv
// Shared types, constants and control-code decoders for the meter reply frame parser.
`default_nettype none

package mrfp_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'h68;
    localparam logic [7:0] END_BYTE     = 8'h16;
    localparam logic [7:0] DATA_OFFSET  = 8'h33;
    localparam logic [7:0] ABNORMAL_BIT = 8'h40;

    localparam logic [8:0] POS_CONTROL = 9'd8;
    localparam logic [8:0] POS_LENGTH  = 9'd9;
    localparam logic [8:0] POS_DATA    = 9'd10;
    localparam logic [8:0] POS_ITEM_HI = 9'd11;

    localparam logic [7:0] MIN_ITEM_LEN = 8'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_FRAME    = 3'd1,
        ST_MISMATCH    = 3'd2,
        ST_BAD_CONTROL = 3'd3,
        ST_ABNORMAL    = 3'd4
    } t_status;

    typedef struct packed {
        logic        hit;
        logic [7:0]  sum;
        logic [47:0] addr;
    } t_sync_info;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_sync_ctl;

    typedef struct packed {
        logic        has;
        logic        is_status;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [7:0]  payload_count;
        logic [47:0] meter_address;
    } t_result;

    function automatic logic is_read_class(input logic [7:0] c);
        logic r;
        unique case (c)
            8'h81, 8'hA1, 8'h82, 8'hA2, 8'h83, 8'hA4,
            8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'hB0: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_ack_class(input logic [7:0] c);
        logic r;
        unique case (c)
            8'h84, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h8C: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mrfp_sync.sv
// Sync search window: keeps the last seven bytes, detects the 0x68 pair, sums the header.
`default_nettype none

module mrfp_sync import mrfp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_sync_ctl  i_ctl,
    input  wire logic [7:0] i_byte,
    output t_sync_info      o_info
);

    logic [7:0] r_win [0:6];
    logic [7:0] w_sum;

    always_comb begin
        w_sum = i_byte;
        for (int k = 0; k < 7; k++) begin
            w_sum = w_sum + r_win[k];
        end
    end

    assign o_info.hit  = (r_win[0] == SYNC_BYTE) && (i_byte == SYNC_BYTE);
    assign o_info.sum  = w_sum;
    assign o_info.addr = {r_win[6], r_win[5], r_win[4], r_win[3], r_win[2], r_win[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int k = 0; k < 7; k++) begin
                r_win[k] <= 8'h00;
            end
        end else if (i_ctl.shift) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= r_win[k + 1];
            end
            r_win[6] <= i_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mrfp_core.sv
// Frame tracker: header capture, checksum, item check, payload decode and status result.
`default_nettype none

module mrfp_core import mrfp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_eob,
    input  wire logic [15:0] i_item,
    input  wire t_sync_info  i_sync,
    output t_sync_ctl        o_sync_ctl,
    output t_result          o_res
);

    logic        r_locked,    n_locked;
    logic [8:0]  r_pos,       n_pos;
    logic [7:0]  r_control,   n_control;
    logic [7:0]  r_length,    n_length;
    logic [7:0]  r_sum,       n_sum;
    logic [47:0] r_addr,      n_addr;
    logic [7:0]  r_item_low,  n_item_low;
    t_status     r_verdict,   n_verdict;

    logic [7:0]  w_data;
    logic        w_rd;
    logic [8:0]  w_data_end;
    logic        w_search;
    t_status     w_st;

    assign w_data     = i_byte - DATA_OFFSET;
    assign w_rd       = is_read_class(r_control) && (r_verdict == ST_OK);
    assign w_data_end = {1'b0, r_length} + POS_DATA;
    assign w_search   = !r_locked && (r_pos == 9'd0);

    assign o_sync_ctl.shift = i_en && w_search;
    assign o_sync_ctl.clear = i_en && i_eob;

    always_comb begin
        n_locked   = r_locked;
        n_pos      = r_pos;
        n_control  = r_control;
        n_length   = r_length;
        n_sum      = r_sum;
        n_addr     = r_addr;
        n_item_low = r_item_low;
        n_verdict  = r_verdict;
        w_st       = ST_OK;
        o_res      = '0;

        if (w_search) begin
            if (i_sync.hit) begin
                n_locked = 1'b1;
                n_pos    = POS_CONTROL;
                n_addr   = i_sync.addr;
                n_sum    = i_sync.sum;
            end
        end else if (r_locked) begin
            n_pos = r_pos + 9'd1;
            priority if (r_pos == POS_CONTROL) begin
                n_control = i_byte;
                n_sum     = r_sum + i_byte;
                priority if ((i_byte & ABNORMAL_BIT) != 8'h00) begin
                    n_verdict = ST_ABNORMAL;
                end else if (is_read_class(i_byte) || is_ack_class(i_byte)) begin
                    n_verdict = ST_OK;
                end else begin
                    n_verdict = ST_BAD_CONTROL;
                end
            end else if (r_pos == POS_LENGTH) begin
                n_length = i_byte;
                n_sum    = r_sum + i_byte;
            end else if (r_pos < w_data_end) begin
                n_sum = r_sum + i_byte;
                if (r_pos == POS_DATA) begin
                    n_item_low = w_data;
                end else if (r_pos == POS_ITEM_HI) begin
                    if (w_rd && ((r_item_low != i_item[7:0]) || (w_data != i_item[15:8]))) begin
                        n_verdict = ST_MISMATCH;
                    end
                end else if (w_rd) begin
                    o_res.has          = 1'b1;
                    o_res.payload_byte = w_data;
                end
            end else if (r_pos == w_data_end) begin
                if (i_byte != r_sum) begin
                    n_verdict = ST_NO_FRAME;
                    n_locked  = 1'b0;
                end
            end else begin
                if (i_byte != END_BYTE) begin
                    n_verdict = ST_NO_FRAME;
                end else begin
                    if (w_rd && (r_length < MIN_ITEM_LEN)) begin
                        n_verdict = ST_MISMATCH;
                    end
                end
                n_locked = 1'b0;
            end
        end

        if (i_eob) begin
            w_st = n_locked ? ST_NO_FRAME : n_verdict;
            o_res.has          = 1'b1;
            o_res.is_status    = 1'b1;
            o_res.payload_byte = 8'h00;
            o_res.status       = w_st;
            o_res.payload_count = (w_st == ST_OK && is_read_class(n_control)
                                   && n_length >= MIN_ITEM_LEN)
                                  ? n_length - MIN_ITEM_LEN : 8'h00;
            o_res.meter_address = (w_st == ST_NO_FRAME) ? 48'h0 : n_addr;
            n_locked   = 1'b0;
            n_pos      = 9'd0;
            n_control  = 8'h00;
            n_length   = 8'h00;
            n_sum      = 8'h00;
            n_addr     = 48'h0;
            n_item_low = 8'h00;
            n_verdict  = ST_NO_FRAME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked   <= 1'b0;
            r_pos      <= 9'd0;
            r_control  <= 8'h00;
            r_length   <= 8'h00;
            r_sum      <= 8'h00;
            r_addr     <= 48'h0;
            r_item_low <= 8'h00;
            r_verdict  <= ST_NO_FRAME;
        end else if (i_en) begin
            r_locked   <= n_locked;
            r_pos      <= n_pos;
            r_control  <= n_control;
            r_length   <= n_length;
            r_sum      <= n_sum;
            r_addr     <= n_addr;
            r_item_low <= n_item_low;
            r_verdict  <= n_verdict;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/meter_reply_frame_parser.sv
// Top level of the meter reply frame parser: input register, frame logic, result register.
//
// Input channel: i_valid / o_stall carry one received byte per transaction together
// with i_end_of_buffer and i_expected_item. Output channel: o_valid / i_stall carry
// one result per transaction: a tentative payload byte (o_is_status = 0) or the
// final status of the buffer (o_is_status = 1) on the byte flagged end of buffer.
// A byte that yields no result produces no output transaction.
// Each result passes two registers: the byte sits in the input register, and the
// result register loads its result when that byte advances out of the input register.
// Throughput: one byte per cycle while o_stall is low; the header/checksum update
// between the two registers is combinational.
// While a result waits under i_stall, the input register still takes one more
// byte; bytes that yield no result keep flowing. o_stall rises only when the
// input register holds a byte whose result cannot enter the full result register.
// Reset (i_rst_n low, synchronous) empties both registers, clears the sync window
// and returns the frame tracker to "no valid frame". After each status result the
// tracker returns to that same state for the next buffer.
`default_nettype none

module meter_reply_frame_parser import mrfp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_end_of_buffer,
    input  wire logic [15:0] i_expected_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_is_status,
    output logic [7:0]       o_payload_byte,
    output logic [2:0]       o_status,
    output logic [7:0]       o_payload_count,
    output logic [47:0]      o_meter_address
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_eob;
    logic [15:0] r_item;

    logic        r_out_valid;
    logic        r_is_status;
    logic [7:0]  r_payload_byte;
    logic [2:0]  r_status;
    logic [7:0]  r_payload_count;
    logic [47:0] r_meter_address;

    t_sync_info  w_sync;
    t_sync_ctl   w_sync_ctl;
    t_result     w_res;
    logic        w_advance;
    logic        w_accept;

    assign w_advance = r_in_valid && (!r_out_valid || !i_stall || !w_res.has);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    mrfp_sync u_sync (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sync_ctl),
        .i_byte  (r_byte),
        .o_info  (w_sync)
    );

    mrfp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_byte     (r_byte),
        .i_eob      (r_eob),
        .i_item     (r_item),
        .i_sync     (w_sync),
        .o_sync_ctl (w_sync_ctl),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
        if (w_accept) begin
            r_byte <= i_rx_byte;
            r_eob  <= i_end_of_buffer;
            r_item <= i_expected_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res.has) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_res.has) begin
            r_is_status     <= w_res.is_status;
            r_payload_byte  <= w_res.payload_byte;
            r_status        <= w_res.status;
            r_payload_count <= w_res.payload_count;
            r_meter_address <= w_res.meter_address;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_is_status     = r_is_status;
    assign o_payload_byte  = r_payload_byte;
    assign o_status        = r_status;
    assign o_payload_count = r_payload_count;
    assign o_meter_address = r_meter_address;

endmodule

`default_nettype wire

>>> rtl/core/mrfp_checker.sv
// Port-level assertions for the meter reply frame parser, bound to the top level.
`default_nettype none

module mrfp_checker import mrfp_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [7:0]  i_rx_byte,
    input wire logic        i_end_of_buffer,
    input wire logic [15:0] i_expected_item,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_is_status,
    input wire logic [7:0]  o_payload_byte,
    input wire logic [2:0]  o_status,
    input wire logic [7:0]  o_payload_count,
    input wire logic [47:0] o_meter_address
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_is_status) && $stable(o_payload_byte)
            && $stable(o_status) && $stable(o_payload_count) && $stable(o_meter_address))
        else $error("result changed while stalled");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_status |-> o_status == ST_OK && o_payload_count == 8'h00
            && o_meter_address == 48'h0)
        else $error("payload transaction carries status fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_status |-> o_payload_byte == 8'h00 && (o_status == ST_OK
            || o_status == ST_NO_FRAME || o_status == ST_MISMATCH
            || o_status == ST_BAD_CONTROL || o_status == ST_ABNORMAL))
        else $error("bad status transaction");

    a_no_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_status && o_status != ST_OK |-> o_payload_count == 8'h00
            && (o_status != ST_NO_FRAME || o_meter_address == 48'h0))
        else $error("failed frame reports count or address");

endmodule

bind meter_reply_frame_parser mrfp_checker u_mrfp_checker (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
// Testbench for meter_reply_frame_parser: random reply buffers against a byte-level parser model.
`timescale 1ns / 100ps

module testbench;
    import mrfp_pkg::*;

    localparam int RX_BYTES = 1350;

    typedef enum int {FAULT_NONE, FAULT_SUM, FAULT_END, FAULT_CUT} t_fault;

    typedef struct {
        logic [7:0]  rx;
        logic        eob;
        logic [15:0] item;
        bit          drain;
    } t_rx_item;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [7:0]  payload_count;
        logic [47:0] meter_address;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_end_of_buffer = 1'b0;
    logic [15:0] i_expected_item = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        o_is_status;
    logic [7:0]  o_payload_byte;
    logic [2:0]  o_status;
    logic [7:0]  o_payload_count;
    logic [47:0] o_meter_address;

    t_rx_item pending_bytes[$];
    t_reply   expected_replies[$];
    logic [7:0] frame_q[$];
    t_rx_item next_in;
    int errors = 0;
    int cycle_n = 0;
    int queued = 0;
    bit quiet;

    // parser model state
    logic [7:0]  win [8];
    logic        lk;
    logic [8:0]  fpos;
    logic [7:0]  ctrl;
    logic [7:0]  lenb;
    logic [7:0]  rsum;
    logic [47:0] addr;
    logic [7:0]  ilow;
    t_status     verdict;

    meter_reply_frame_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_expected_item (i_expected_item),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_is_status     (o_is_status),
        .o_payload_byte  (o_payload_byte),
        .o_status        (o_status),
        .o_payload_count (o_payload_count),
        .o_meter_address (o_meter_address)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic read_code(input logic [7:0] c);
        case (c)
            8'h81, 8'hA1, 8'h82, 8'hA2, 8'h83, 8'hA4,
            8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'hB0: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic ack_code(input logic [7:0] c);
        case (c)
            8'h84, 8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h8C: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_parser();
        int i;
        for (i = 0; i < 8; i++) win[i] = '0;
        lk = 1'b0;
        fpos = '0;
        ctrl = '0;
        lenb = '0;
        rsum = '0;
        addr = '0;
        ilow = '0;
        verdict = ST_NO_FRAME;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eob, input logic [15:0] item);
        t_reply r;
        bit have;
        int i, p, len;
        logic [7:0] d, s;
        logic rd;
        t_status st;
        have = 1'b0;
        r = '0;
        if (!lk && fpos == 0) begin
            for (i = 0; i < 7; i++) win[i] = win[i + 1];
            win[7] = b;
            if (win[0] == SYNC_BYTE && win[7] == SYNC_BYTE) begin
                s = '0;
                for (i = 0; i < 8; i++) s = s + win[i];
                lk = 1'b1;
                fpos = 9'd8;
                addr = {win[6], win[5], win[4], win[3], win[2], win[1]};
                rsum = s;
            end
        end else if (lk) begin
            p = int'(fpos);
            len = int'(lenb);
            if (p == POS_CONTROL) begin
                ctrl = b;
                rsum = rsum + b;
                if (b & ABNORMAL_BIT) verdict = ST_ABNORMAL;
                else if (read_code(b) || ack_code(b)) verdict = ST_OK;
                else verdict = ST_BAD_CONTROL;
            end else if (p == POS_LENGTH) begin
                lenb = b;
                rsum = rsum + b;
            end else if (p < POS_DATA + len) begin
                d = b - DATA_OFFSET;
                rd = read_code(ctrl) && verdict == ST_OK;
                rsum = rsum + b;
                if (p == POS_DATA) begin
                    ilow = d;
                end else if (p == POS_ITEM_HI) begin
                    if (rd && (ilow != item[7:0] || d != item[15:8])) verdict = ST_MISMATCH;
                end else if (rd) begin
                    r.payload_byte = d;
                    have = 1'b1;
                end
            end else if (p == POS_DATA + len) begin
                if (b != rsum) begin
                    verdict = ST_NO_FRAME;
                    lk = 1'b0;
                end
            end else begin
                if (b != END_BYTE) verdict = ST_NO_FRAME;
                else if (read_code(ctrl) && verdict == ST_OK && len < MIN_ITEM_LEN)
                    verdict = ST_MISMATCH;
                lk = 1'b0;
            end
            fpos = 9'(p + 1);
        end
        if (eob) begin
            // status replaces a payload byte arriving on the same transaction
            st = lk ? ST_NO_FRAME : verdict;
            r = '0;
            r.is_status = 1'b1;
            r.status = st;
            if (st == ST_OK && read_code(ctrl) && lenb >= MIN_ITEM_LEN)
                r.payload_count = lenb - MIN_ITEM_LEN;
            r.meter_address = (st == ST_NO_FRAME) ? 48'd0 : addr;
            have = 1'b1;
            clear_parser();
        end
        if (have) expected_replies.push_back(r);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if ($urandom_range(9) == 0) v = SYNC_BYTE;
        return v;
    endfunction

    task automatic queue_buffer(input int cut, input int item_at, input logic [15:0] item,
                                input bit drain);
        t_rx_item t;
        int i;
        for (i = 0; i < cut; i++) begin
            t.rx = frame_q[i];
            t.eob = (i == cut - 1);
            t.item = (i == item_at) ? item : 16'($urandom_range(65535));
            t.drain = drain && i == 0;
            pending_bytes.push_back(t);
        end
        queued += cut;
        frame_q.delete();
    endtask

    task automatic add_frame(input logic [7:0] c, input int len, input bit item_ok,
                             input t_fault fault, input int lead, input int tail,
                             input bit drain);
        logic [15:0] item, seen;
        logic [7:0] sum;
        int i, cut;
        item = 16'($urandom_range(65535));
        for (i = 0; i < lead; i++) frame_q.push_back(noise_byte());
        frame_q.push_back(SYNC_BYTE);
        for (i = 0; i < 6; i++) frame_q.push_back(8'($urandom_range(255)));
        frame_q.push_back(SYNC_BYTE);
        frame_q.push_back(c);
        frame_q.push_back(len[7:0]);
        for (i = 0; i < len; i++) begin
            if (i == 0) frame_q.push_back(item[7:0] + DATA_OFFSET);
            else if (i == 1) frame_q.push_back(item[15:8] + DATA_OFFSET);
            else frame_q.push_back(8'($urandom_range(255)));
        end
        sum = '0;
        for (i = lead; i < frame_q.size(); i++) sum = sum + frame_q[i];
        if (fault == FAULT_SUM) sum = sum ^ (8'h1 << $urandom_range(7));
        frame_q.push_back(sum);
        frame_q.push_back(fault == FAULT_END ? END_BYTE ^ (8'h1 << $urandom_range(7))
                                             : END_BYTE);
        for (i = 0; i < tail; i++) frame_q.push_back(noise_byte());
        cut = frame_q.size();
        if (fault == FAULT_CUT) cut = $urandom_range(cut - 1, 1);
        seen = item_ok ? item : item ^ (16'h1 << $urandom_range(15));
        queue_buffer(cut, lead + 11, seen, drain);
    endtask

    function automatic logic [7:0] pick_control();
        logic [7:0] c;
        int k;
        k = $urandom_range(99);
        c = 8'($urandom_range(255));
        if (k < 55) begin
            while (!read_code(c)) c = 8'($urandom_range(255));
        end else if (k < 70) begin
            while (!ack_code(c)) c = 8'($urandom_range(255));
        end else if (k < 80) begin
            c = c | ABNORMAL_BIT;
        end else begin
            c = c & ~ABNORMAL_BIT;
        end
        return c;
    endfunction

    task automatic build_stimulus();
        int nbuf, n, k, len;
        t_fault fault;
        // lone end-of-buffer byte, all ones
        frame_q.push_back(8'hFF);
        queue_buffer(1, 0, 16'hFFFF, 1'b0);
        add_frame(8'h91, 3, 1'b1, FAULT_NONE, 0, 0, 1'b0);
        // read frame too short to carry an item id
        add_frame(8'h81, 1, 1'b1, FAULT_NONE, 0, 0, 1'b0);
        nbuf = 0;
        while (queued < RX_BYTES) begin
            nbuf++;
            if ($urandom_range(99) < 12) begin
                n = $urandom_range(6, 1);
                repeat (n) frame_q.push_back(noise_byte());
                queue_buffer(n, $urandom_range(n - 1), 16'($urandom_range(65535)),
                             nbuf % 16 == 15);
            end else begin
                len = ($urandom_range(79) == 0) ? 255 : $urandom_range(10);
                k = $urandom_range(99);
                fault = (k < 8) ? FAULT_SUM : (k < 16) ? FAULT_END :
                        (k < 26) ? FAULT_CUT : FAULT_NONE;
                add_frame(pick_control(), len, $urandom_range(9) != 0, fault,
                          $urandom_range(3), $urandom_range(2), nbuf % 16 == 15);
            end
        end
    endtask

    assign quiet = (cycle_n >= 600 && cycle_n < 1000);

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                parse_byte(i_rx_byte, i_end_of_buffer, i_expected_item);
            if (!i_valid || !o_stall) begin
                if (pending_bytes.size() == 0 || (!quiet && $urandom_range(99) < 9) ||
                    (pending_bytes[0].drain && expected_replies.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    next_in = pending_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_rx_byte <= next_in.rx;
                    i_end_of_buffer <= next_in.eob;
                    i_expected_item <= next_in.item;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reply got, want;
        cycle_n <= cycle_n + 1;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_is_status, o_payload_byte, o_status, o_payload_count,
                       o_meter_address};
                if (expected_replies.size() == 0) begin
                    if (errors < 40)
                        $display("%0t: unexpected result: is_status=%0d byte=%h status=%0d",
                                 $time, got.is_status, got.payload_byte, got.status);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want) begin
                        if (errors < 40)
                            $display("%0t: mismatch: expected is_status=%0d byte=%h ",
                                     $time, want.is_status, want.payload_byte,
                                     "status=%0d count=%0d addr=%h, ", want.status,
                                     want.payload_count, want.meter_address,
                                     "actual is_status=%0d byte=%h ", got.is_status,
                                     got.payload_byte,
                                     "status=%0d count=%0d addr=%h", got.status,
                                     got.payload_count, got.meter_address);
                        errors++;
                    end
                end
            end
            i_stall <= !quiet && ($urandom_range(99) < 9);
        end
    end

    initial begin
        clear_parser();
        build_stimulus();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/core/mrfp_pkg.sv
rtl/core/mrfp_sync.sv
rtl/core/mrfp_core.sv
rtl/core/meter_reply_frame_parser.sv
rtl/core/mrfp_checker.sv
tb/sv/testbench.sv
